@@ sv/qawt_pkg.sv @@
// types, byte codes and helper functions for the quote aware whitespace tokenizer
// no dependencies; used by quote_aware_whitespace_tokenizer_core
package qawt_pkg;

	localparam int CharW  = 8;
	localparam int CountW = 8;

	localparam logic [CharW-1:0] ChrSpace  = 8'h20;
	localparam logic [CharW-1:0] ChrFf     = 8'h0C;
	localparam logic [CharW-1:0] ChrLf     = 8'h0A;
	localparam logic [CharW-1:0] ChrCr     = 8'h0D;
	localparam logic [CharW-1:0] ChrTab    = 8'h09;
	localparam logic [CharW-1:0] ChrVt     = 8'h0B;
	localparam logic [CharW-1:0] ChrDquote = 8'h22;
	localparam logic [CharW-1:0] ChrSquote = 8'h27;
	localparam logic [CharW-1:0] ChrBslash = 8'h5C;

	localparam logic [CountW-1:0] CountMax = '1;

	typedef struct packed {
		logic [CharW-1:0] char_in;
		logic             end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [CharW-1:0]  char_out;
		logic              has_char;
		logic              token_first;
		logic              token_last;
		logic              string_done;
		logic [CountW-1:0] token_count;
	} out_word_t;

	function automatic logic is_space(input logic [CharW-1:0] c);
		return (c == ChrSpace) || (c == ChrFf) || (c == ChrLf) ||
			(c == ChrCr) || (c == ChrTab) || (c == ChrVt);
	endfunction

	function automatic logic [CountW-1:0] count_inc(input logic [CountW-1:0] n);
		return (n == CountMax) ? CountMax : n + CountW'(1);
	endfunction

endpackage

@@ sv/quote_aware_whitespace_tokenizer_core.sv @@
// quote aware whitespace tokenizer: byte stream in, token bytes with first/last marks out
// depends on qawt_pkg
// timing: an accepted byte goes to the input register; a word that it causes is registered
//   at out_data when that register advances; each token byte appears one byte later
// throughput: one input word per cycle while out_ready is high, set by the single
//   input-register to output-register update of the flag bits and the held byte
// reset: arst_n clears valid flags, tokenizer flags, hold flag and token count at once
module quote_aware_whitespace_tokenizer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qawt_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qawt_pkg::out_word_t out_data
);

	logic               valid_s1;
	qawt_pkg::in_word_t data_s1;

	logic                           inside_token_q;
	logic                           dquote_q;
	logic                           squote_q;
	logic                           escape_q;
	logic                           held_valid_q;
	logic [qawt_pkg::CharW-1:0]     held_char_q;
	logic                           held_first_q;
	logic [qawt_pkg::CountW-1:0]    count_q;

	logic                out_valid_q;
	qawt_pkg::out_word_t out_data_q;

	logic                           advance;
	logic                           emit;
	qawt_pkg::out_word_t            res;
	logic                           inside_token_d;
	logic                           dquote_d;
	logic                           squote_d;
	logic                           escape_d;
	logic                           held_valid_d;
	logic [qawt_pkg::CharW-1:0]     held_char_d;
	logic                           held_first_d;
	logic [qawt_pkg::CountW-1:0]    count_d;
	logic [qawt_pkg::CharW-1:0]     c;
	logic                           space;
	logic [qawt_pkg::CountW-1:0]    cnt_inc;

	// the stage may move unless it would write a word into a full, stalled output
	assign advance  = valid_s1 && (!out_valid_q || out_ready || !emit);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		c       = data_s1.char_in;
		space   = qawt_pkg::is_space(c);
		cnt_inc = qawt_pkg::count_inc(count_q);

		emit           = 1'b0;
		res            = '0;
		inside_token_d = inside_token_q;
		dquote_d       = dquote_q;
		squote_d       = squote_q;
		escape_d       = escape_q;
		held_valid_d   = held_valid_q;
		held_char_d    = held_char_q;
		held_first_d   = held_first_q;
		count_d        = count_q;

		if (data_s1.end_of_string) begin
			emit = 1'b1;
			res.string_done = 1'b1;
			if (held_valid_q) begin
				res.char_out    = held_char_q;
				res.has_char    = 1'b1;
				res.token_first = held_first_q;
				res.token_last  = 1'b1;
				res.token_count = cnt_inc;
			end else begin
				res.token_count = count_q;
			end
			inside_token_d = 1'b0;
			dquote_d       = 1'b0;
			squote_d       = 1'b0;
			escape_d       = 1'b0;
			held_valid_d   = 1'b0;
			held_char_d    = '0;
			held_first_d   = 1'b0;
			count_d        = '0;
		end else if (!inside_token_q && space) begin
			// leading or repeated whitespace, dropped
		end else if (inside_token_q && space && !dquote_q && !squote_q && !escape_q) begin
			// splitting whitespace closes the token
			count_d = cnt_inc;
			if (held_valid_q) begin
				emit            = 1'b1;
				res.char_out    = held_char_q;
				res.has_char    = 1'b1;
				res.token_first = held_first_q;
				res.token_last  = 1'b1;
				res.token_count = cnt_inc;
			end
			held_valid_d   = 1'b0;
			held_char_d    = '0;
			held_first_d   = 1'b0;
			inside_token_d = 1'b0;
			escape_d       = 1'b0;
		end else begin
			inside_token_d = 1'b1;
			if (c == qawt_pkg::ChrDquote && !squote_q && !escape_q) begin
				dquote_d = !dquote_q;
			end else if (c == qawt_pkg::ChrSquote && !dquote_q && !escape_q) begin
				squote_d = !squote_q;
			end
			escape_d = (c == qawt_pkg::ChrBslash) ? !escape_q : 1'b0;
			if (held_valid_q) begin
				emit            = 1'b1;
				res.char_out    = held_char_q;
				res.has_char    = 1'b1;
				res.token_first = held_first_q;
				res.token_count = count_q;
			end
			held_valid_d = 1'b1;
			held_char_d  = c;
			held_first_d = !inside_token_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_token_q <= 1'b0;
			dquote_q       <= 1'b0;
			squote_q       <= 1'b0;
			escape_q       <= 1'b0;
			held_valid_q   <= 1'b0;
			held_first_q   <= 1'b0;
			count_q        <= '0;
		end else if (advance) begin
			inside_token_q <= inside_token_d;
			dquote_q       <= dquote_d;
			squote_q       <= squote_d;
			escape_q       <= escape_d;
			held_valid_q   <= held_valid_d;
			held_first_q   <= held_first_d;
			count_q        <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_char_q <= held_char_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a token in progress always has its latest byte in the hold register
	a_token_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		inside_token_q |-> held_valid_q)
		else $error("inside a token with nothing held");

	// an end word leaves all tokenizer state cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && data_s1.end_of_string) |=>
			(!inside_token_q && !held_valid_q && !dquote_q && !squote_q &&
			 !escape_q && count_q == '0))
		else $error("end word did not clear state");

	// a word without a token byte is only ever the end report
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.has_char) |-> out_data.string_done)
		else $error("empty word that is not an end report");

	// first and last marks only ride on real token bytes
	a_marks_need_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.token_first || out_data.token_last)) |-> out_data.has_char)
		else $error("token mark without a byte");

endmodule

@@ dv/quote_aware_whitespace_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for quote_aware_whitespace_tokenizer_core: scripted strings, then random
// quoted and escaped strings under several idle and stall patterns; depends on qawt_pkg
module quote_aware_whitespace_tokenizer_core_tb;

	typedef struct packed {
		qawt_pkg::in_word_t  word;
		bit                  typed;
		qawt_pkg::out_word_t want;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	qawt_pkg::in_word_t  in_data;
	logic                out_valid;
	logic                out_ready;
	qawt_pkg::out_word_t out_data;

	// tokenizer state as this bench sees it
	bit                          in_tok;
	bit                          in_dq;
	bit                          in_sq;
	bit                          esc;
	bit                          hold_v;
	logic [qawt_pkg::CharW-1:0]  hold_c;
	bit                          hold_first;
	logic [qawt_pkg::CountW-1:0] tok_cnt;

	qawt_pkg::out_word_t token_bytes_due[$];
	script_row_t         script[$];

	int send_idle_pct;
	int stall_pct;
	int hold_request;
	int hold_left;
	int bad_fields;
	int words_sent;
	int counted_words;
	int words_checked;
	int strings_sent;
	bit saw_count_max;

	quote_aware_whitespace_tokenizer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d words still due", token_bytes_due.size());
		$display("quote_aware_whitespace_tokenizer_core_tb NOT OK");
		$finish;
	end

	function automatic bit is_blank(input logic [qawt_pkg::CharW-1:0] c);
		case (c) inside
			qawt_pkg::ChrSpace, qawt_pkg::ChrFf, qawt_pkg::ChrLf, qawt_pkg::ChrCr,
				qawt_pkg::ChrTab, qawt_pkg::ChrVt: is_blank = 1'b1;
			default: is_blank = 1'b0;
		endcase
	endfunction

	// advance the tokenizer by one accepted word and give the word it releases, if any
	task automatic split_byte(input qawt_pkg::in_word_t w, output bit made,
			output qawt_pkg::out_word_t word);
		logic [qawt_pkg::CharW-1:0]  c;
		logic [qawt_pkg::CountW-1:0] next_cnt;
		bit                          starting;
		c = w.char_in;
		made = 1'b0;
		word = '0;
		next_cnt = (tok_cnt == qawt_pkg::CountMax) ? qawt_pkg::CountMax : tok_cnt + 8'd1;
		if (w.end_of_string) begin
			made = 1'b1;
			if (hold_v)
				word = '{hold_c, 1'b1, hold_first, 1'b1, 1'b1, next_cnt};
			else
				word = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, tok_cnt};
			in_tok = 0; in_dq = 0; in_sq = 0; esc = 0;
			hold_v = 0; hold_c = '0; hold_first = 0; tok_cnt = '0;
		end else if (!in_tok && is_blank(c)) begin
			// leading or repeated whitespace is dropped
		end else if (in_tok && is_blank(c) && !in_dq && !in_sq && !esc) begin
			tok_cnt = next_cnt;
			if (hold_v) begin
				made = 1'b1;
				word = '{hold_c, 1'b1, hold_first, 1'b1, 1'b0, tok_cnt};
			end
			hold_v = 0; hold_c = '0; hold_first = 0;
			in_tok = 0; esc = 0;
		end else begin
			starting = !in_tok;
			in_tok = 1;
			if (c == qawt_pkg::ChrDquote && !in_sq && !esc)
				in_dq = !in_dq;
			else if (c == qawt_pkg::ChrSquote && !in_dq && !esc)
				in_sq = !in_sq;
			else if (c == qawt_pkg::ChrBslash)
				esc = !esc;
			if (c != qawt_pkg::ChrBslash)
				esc = 0;
			if (hold_v) begin
				made = 1'b1;
				word = '{hold_c, 1'b1, hold_first, 1'b0, 1'b0, tok_cnt};
			end
			hold_v = 1;
			hold_c = c;
			hold_first = starting;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (bad_fields < 50)
			$display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		bad_fields++;
	endtask

	// present one word from the falling edge and hold it until accepted
	task automatic send_word(input qawt_pkg::in_word_t w, input bit typed,
			input qawt_pkg::out_word_t want);
		bit                  made;
		qawt_pkg::out_word_t word;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (w.end_of_string || in_tok || !is_blank(w.char_in))
			counted_words++;
		words_sent++;
		split_byte(w, made, word);
		if (made)
			token_bytes_due.push_back(typed ? want : word);
	endtask

	task automatic send_plain(input logic [qawt_pkg::CharW-1:0] c, input bit eos);
		qawt_pkg::in_word_t w;
		w.char_in = c;
		w.end_of_string = eos;
		send_word(w, 1'b0, '0);
		if (eos)
			strings_sent++;
	endtask

	function automatic logic [qawt_pkg::CharW-1:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 25) begin
			case ($urandom_range(5))
				0: pick_char = qawt_pkg::ChrSpace;
				1: pick_char = qawt_pkg::ChrFf;
				2: pick_char = qawt_pkg::ChrLf;
				3: pick_char = qawt_pkg::ChrCr;
				4: pick_char = qawt_pkg::ChrTab;
				default: pick_char = qawt_pkg::ChrVt;
			endcase
		end else if (r < 33) pick_char = qawt_pkg::ChrDquote;
		else if (r < 41) pick_char = qawt_pkg::ChrSquote;
		else if (r < 50) pick_char = qawt_pkg::ChrBslash;
		else if (r < 54) pick_char = 8'h00;
		else pick_char = qawt_pkg::CharW'($urandom_range(255));
	endfunction

	task automatic send_string(input int len);
		for (int i = 0; i < len; i++)
			send_plain(pick_char(), 1'b0);
		send_plain(qawt_pkg::CharW'($urandom_range(255)), 1'b1);
	endtask

	task automatic drain_due();
		while (token_bytes_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic script_row_t row(input logic [qawt_pkg::CharW-1:0] c, input bit eos);
		row = '0;
		row.word.char_in = c;
		row.word.end_of_string = eos;
	endfunction

	function automatic script_row_t row_typed(input logic [qawt_pkg::CharW-1:0] c,
			input bit eos, input qawt_pkg::out_word_t want);
		row_typed = row(c, eos);
		row_typed.typed = 1'b1;
		row_typed.want = want;
	endfunction

	// receiver: random stalls, or a long counted hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = 400;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		qawt_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (token_bytes_due.size() == 0) begin
				report_mismatch("word with nothing due, char", int'(out_data.char_out), 0);
			end else begin
				want = token_bytes_due.pop_front();
				words_checked++;
				if (out_data.char_out !== want.char_out)
					report_mismatch("char_out", int'(out_data.char_out),
						int'(want.char_out));
				if (out_data.has_char !== want.has_char)
					report_mismatch("has_char", int'(out_data.has_char),
						int'(want.has_char));
				if (out_data.token_first !== want.token_first)
					report_mismatch("token_first", int'(out_data.token_first),
						int'(want.token_first));
				if (out_data.token_last !== want.token_last)
					report_mismatch("token_last", int'(out_data.token_last),
						int'(want.token_last));
				if (out_data.string_done !== want.string_done)
					report_mismatch("string_done", int'(out_data.string_done),
						int'(want.string_done));
				if (out_data.token_count !== want.token_count)
					report_mismatch("token_count", int'(out_data.token_count),
						int'(want.token_count));
				if (want.token_count == qawt_pkg::CountMax)
					saw_count_max = 1'b1;
			end
		end
	end

	initial begin
		int phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		bad_fields = 0;
		words_sent = 0;
		counted_words = 0;
		words_checked = 0;
		strings_sent = 0;
		saw_count_max = 1'b0;
		in_tok = 0; in_dq = 0; in_sq = 0; esc = 0;
		hold_v = 0; hold_c = '0; hold_first = 0; tok_cnt = '0;

		// end on an empty string, zero byte token, skipped blanks, quoting and escapes,
		// then an end with an unclosed single quote and a pending escape
		script.push_back(row_typed(8'hA5, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0}));
		script.push_back(row(8'h00, 1'b0));
		script.push_back(row_typed(qawt_pkg::ChrSpace, 1'b0,
			'{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'd1}));
		script.push_back(row(qawt_pkg::ChrTab, 1'b0));
		script.push_back(row(qawt_pkg::ChrLf, 1'b0));
		script.push_back(row(8'hFF, 1'b0));
		script.push_back(row(qawt_pkg::ChrDquote, 1'b0));
		script.push_back(row(qawt_pkg::ChrSpace, 1'b0));
		script.push_back(row(qawt_pkg::ChrSquote, 1'b0));
		script.push_back(row(qawt_pkg::ChrDquote, 1'b0));
		script.push_back(row(qawt_pkg::ChrBslash, 1'b0));
		script.push_back(row(qawt_pkg::ChrCr, 1'b0));
		script.push_back(row(qawt_pkg::ChrBslash, 1'b0));
		script.push_back(row(qawt_pkg::ChrBslash, 1'b0));
		script.push_back(row(qawt_pkg::ChrVt, 1'b0));
		script.push_back(row(qawt_pkg::ChrFf, 1'b0));
		script.push_back(row(qawt_pkg::ChrSquote, 1'b0));
		script.push_back(row(qawt_pkg::ChrDquote, 1'b0));
		script.push_back(row(qawt_pkg::ChrSpace, 1'b0));
		script.push_back(row(qawt_pkg::ChrBslash, 1'b0));
		script.push_back(row_typed(8'h00, 1'b1,
			'{qawt_pkg::ChrBslash, 1'b1, 1'b0, 1'b1, 1'b1, 8'd3}));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_word(script[i].word, script[i].typed, script[i].want);
		@(negedge clk);
		in_valid <= 1'b0;
		drain_due();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 87; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 87; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			if (phase == 0) begin
				// enough short tokens in one string to push the count past its ceiling
				for (int t = 0; t < 270; t++) begin
					send_plain(qawt_pkg::CharW'($urandom_range(128, 255)), 1'b0);
					send_plain(qawt_pkg::ChrSpace, 1'b0);
				end
				send_plain(qawt_pkg::CharW'($urandom_range(255)), 1'b1);
				// receiver holds off while words keep coming, so the input backs up
				hold_request = 1;
			end
			phase_end = counted_words + 220;
			while (counted_words < phase_end) begin
				send_string($urandom_range(0, 24));
				if (phase == 1 && counted_words > phase_end - 200 && !saw_count_max) begin
					// pause the sender until every due word has come back
					@(negedge clk);
					in_valid <= 1'b0;
					drain_due();
					saw_count_max = saw_count_max;
				end
			end
			@(negedge clk);
			in_valid <= 1'b0;
			drain_due();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		drain_due();
		repeat (20) @(posedge clk);
		if (token_bytes_due.size() != 0)
			report_mismatch("words never seen", token_bytes_due.size(), 0);

		$display("sent %0d words in %0d strings, checked %0d result words, %0d bad fields",
			words_sent, strings_sent, words_checked, bad_fields);
		$display("quoting, escapes, all blank kinds, four idle patterns; count ceiling hit: %0d",
			saw_count_max);
		if (bad_fields == 0)
			$display("quote_aware_whitespace_tokenizer_core_tb OK");
		else
			$display("quote_aware_whitespace_tokenizer_core_tb NOT OK");
		$finish;
	end

endmodule
